// ===== rtl/core/sdtq_pkg.sv =====
`default_nettype none

package sdtq_pkg;

    localparam int ID_SLOTS       = 16;
    localparam int NUM_TIMERS_DEF = 16;

    localparam int ACT_W  = 2;
    localparam int ID_W   = 4;
    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int DL_W   = SEC_W + USEC_W;

    localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
    localparam logic [USEC_W:0]   USEC_PER_SEC = 21'd1000000;

    localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STOP    = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_deadline_timer_queue.sv =====
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------------
// command  | in        | i_valid / o_ready   | i_action i_timer_id i_delay_sec
//          |           |                     | i_delay_usec i_elapsed_us
// result   | out       | o_valid / i_ready   | o_fired o_fired_id o_status o_last
//
// o_ready is high only in idle. After a command transaction a second pulse or an advance
// goes straight to the expiry check; a start of an inactive slot adds the delay, carries
// and saturates the deadline, walks the queue with one RAM read per deadline compared and
// inserts; a stop searches the queue for the slot and removes it. Expired timers then pop.
// Reset is synchronous; queue and slot flags clear at once, the deadline RAM is not cleared.
// A stalled result register holds the sequencer before the next result is produced.

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [ID_W-1:0]   i_timer_id,
    input  wire logic [SEC_W-1:0]  i_delay_sec,
    input  wire logic [USEC_W-1:0] i_delay_usec,
    input  wire logic [USEC_W-1:0] i_elapsed_us,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_fired,
    output logic [ID_W-1:0]        o_fired_id,
    output logic                   o_status,
    output logic                   o_last
);

    localparam int SLOTS = (NUM_TIMERS < ID_SLOTS) ? NUM_TIMERS : ID_SLOTS;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD     = 4'd1;
    localparam logic [3:0] S_FIX     = 4'd2;
    localparam logic [3:0] S_INS_RD  = 4'd3;
    localparam logic [3:0] S_INS_CMP = 4'd4;
    localparam logic [3:0] S_INS_DO  = 4'd5;
    localparam logic [3:0] S_REM     = 4'd6;
    localparam logic [3:0] S_EXP_CK  = 4'd7;
    localparam logic [3:0] S_EXP_CMP = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;

    logic [3:0]        r_state;
    logic [SEC_W-1:0]  r_upsec;
    logic [USEC_W-1:0] r_upmic;
    logic [SLOTS-1:0]  r_active;
    logic [ID_W-1:0]   r_order [SLOTS];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_pos;

    logic [ID_W-1:0]   r_id;
    logic [SEC_W-1:0]  r_dsec;
    logic [USEC_W-1:0] r_dusec;
    logic              r_status;
    logic [USEC_W:0]   r_usum;
    logic [SEC_W:0]    r_ssum;
    logic [DL_W-1:0]   r_new;

    logic              r_pend_v;
    logic [ID_W-1:0]   r_pend_id;

    logic              r_o_valid;
    logic              r_o_fired;
    logic [ID_W-1:0]   r_o_id;
    logic              r_o_status;
    logic              r_o_last;

    logic [DL_W-1:0]   r_mem [SLOTS];
    logic [DL_W-1:0]   r_rdata;

    logic              in_acc;
    logic              out_free;
    logic              id_ok;
    logic [IW-1:0]     in_idx;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     pos_idx;
    logic [USEC_W:0]   adv_sum;
    logic              fix_carry;
    logic [USEC_W-1:0] fix_u;
    logic [SEC_W:0]    fix_s;
    logic [DL_W-1:0]   n_dl;
    logic              expired;

    assign o_ready    = (r_state == S_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign out_free   = !r_o_valid || i_ready;
    assign id_ok      = ({1'b0, i_timer_id} < (ID_W + 1)'(SLOTS));
    assign in_idx     = i_timer_id[IW-1:0];
    assign pos_idx    = r_pos[IW-1:0];
    assign rd_addr    = (r_state == S_INS_RD) ? r_order[pos_idx][IW-1:0]
                                              : r_order[0][IW-1:0];
    assign adv_sum    = {1'b0, r_upmic} + {1'b0, i_elapsed_us};

    // carry the microseconds, then saturate a deadline past the seconds range
    assign fix_carry  = (r_usum >= USEC_PER_SEC);
    assign fix_u      = fix_carry ? USEC_W'(r_usum - USEC_PER_SEC) : r_usum[USEC_W-1:0];
    assign fix_s      = r_ssum + (SEC_W + 1)'(fix_carry);
    assign n_dl       = fix_s[SEC_W] ? {{SEC_W{1'b1}}, USEC_MAX}
                                     : {fix_s[SEC_W-1:0], fix_u};

    assign expired    = !(r_rdata > {r_upsec, r_upmic});

    assign o_valid    = r_o_valid;
    assign o_fired    = r_o_fired;
    assign o_fired_id = r_o_id;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

    // deadline RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIX) begin
            r_mem[r_id[IW-1:0]] <= n_dl;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_upsec   <= '0;
            r_upmic   <= '0;
            r_active  <= '0;
            r_count   <= '0;
            r_pos     <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_id     <= i_timer_id;
                        r_dsec   <= i_delay_sec;
                        r_dusec  <= (i_delay_usec > USEC_MAX) ? USEC_MAX : i_delay_usec;
                        r_status <= 1'b0;
                        r_pos    <= '0;
                        r_state  <= S_EXP_CK;
                        case (i_action)
                            ACT_SECOND: begin
                                r_upsec <= r_upsec + SEC_W'(1);
                                r_upmic <= '0;
                            end
                            ACT_ADVANCE: begin
                                r_upmic <= (adv_sum > {1'b0, USEC_MAX}) ? USEC_MAX
                                                                        : adv_sum[USEC_W-1:0];
                            end
                            ACT_START: begin
                                if (id_ok && r_active[in_idx]) begin
                                    r_status <= 1'b1;
                                end else if (id_ok) begin
                                    r_state <= S_ADD;
                                end
                            end
                            ACT_STOP: begin
                                if (id_ok && r_active[in_idx]) begin
                                    r_state <= S_REM;
                                end
                            end
                            default: begin
                                r_state <= S_EXP_CK;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    r_usum  <= {1'b0, r_upmic} + {1'b0, r_dusec};
                    r_ssum  <= {1'b0, r_upsec} + {1'b0, r_dsec};
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_new                  <= n_dl;
                    r_active[r_id[IW-1:0]] <= 1'b1;
                    r_pos                  <= '0;
                    r_state                <= S_INS_RD;
                end
                S_INS_RD: begin
                    r_state <= (r_pos == r_count) ? S_INS_DO : S_INS_CMP;
                end
                S_INS_CMP: begin
                    // stop at the first queued deadline strictly later than the new one
                    if (r_rdata > r_new) begin
                        r_state <= S_INS_DO;
                    end else begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_DO: begin
                    if (r_count < CW'(SLOTS)) begin
                        for (int i = 1; i < SLOTS; i++) begin
                            if ((CW'(i) > r_pos) && (CW'(i) <= r_count)) begin
                                r_order[i] <= r_order[i-1];
                            end
                        end
                        r_order[pos_idx] <= r_id;
                        r_count          <= r_count + CW'(1);
                    end
                    r_state <= S_EXP_CK;
                end
                S_REM: begin
                    if (r_pos == r_count) begin
                        r_state <= S_EXP_CK;
                    end else if (r_order[pos_idx] == r_id) begin
                        for (int i = 0; i < SLOTS - 1; i++) begin
                            if (CW'(i) >= r_pos) begin
                                r_order[i] <= r_order[i+1];
                            end
                        end
                        r_count                <= r_count - CW'(1);
                        r_active[r_id[IW-1:0]] <= 1'b0;
                        r_state                <= S_EXP_CK;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                S_EXP_CK: begin
                    r_state <= (r_count == '0) ? S_FIN : S_EXP_CMP;
                end
                S_EXP_CMP: begin
                    if (!expired) begin
                        r_state <= S_FIN;
                    end else if (!r_pend_v || out_free) begin
                        // previous pop is not the final result: send it with last low
                        if (r_pend_v) begin
                            r_o_valid  <= 1'b1;
                            r_o_fired  <= 1'b1;
                            r_o_id     <= r_pend_id;
                            r_o_status <= 1'b0;
                            r_o_last   <= 1'b0;
                        end
                        r_pend_v  <= 1'b1;
                        r_pend_id <= r_order[0];
                        for (int i = 0; i < SLOTS - 1; i++) begin
                            r_order[i] <= r_order[i+1];
                        end
                        r_count                     <= r_count - CW'(1);
                        r_active[r_order[0][IW-1:0]] <= 1'b0;
                        r_state                     <= S_EXP_CK;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_fired  <= r_pend_v;
                        r_o_id     <= r_pend_v ? r_pend_id : '0;
                        r_o_status <= r_pend_v ? 1'b0 : r_status;
                        r_o_last   <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("queue count beyond slot count");

    a_active_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_active) == int'(r_count)))
        else $error("active slots and queue length disagree");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("ready right after a command transaction");

    a_pop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP_CMP && expired && r_pend_v && !out_free)
        |=> (r_state == S_EXP_CMP && $stable(r_count)))
        else $error("queue popped while result register stalled");

endmodule

`default_nettype wire
